[src/iswm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iswm_pkg: shared types and constants of the I2C slave word mailbox
// Opcodes, decoded command kinds, payload structs and the queue entry
// passed from the front end to the execution unit.
// ----------------------------------------------------------------------------
package iswm_pkg;

    localparam int BUF_DEPTH_DEF = 32;
    localparam int TX_BYTES      = 4;
    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 32;
    localparam int OUT_COUNT_W   = 6;

    typedef enum logic [3:0] {
        OPC_ADDR_WRITE = 4'd0,
        OPC_BYTE_RX    = 4'd1,
        OPC_STOP       = 4'd2,
        OPC_RX_NACK    = 4'd3,
        OPC_ADDR_READ  = 4'd4,
        OPC_TX_ACK     = 4'd5,
        OPC_TX_DONE    = 4'd6,
        OPC_BUS_ERR    = 4'd7,
        OPC_NO_INFO    = 4'd8,
        OPC_HOST_POP   = 4'd9,
        OPC_SET_RESP   = 4'd10
    } opcode_t;

    // Decoded command kinds; events that only acknowledge map to K_NONE
    typedef enum logic [3:0] {
        K_NONE,
        K_ADDR_WRITE,
        K_BYTE_RX,
        K_STOP,
        K_RX_NACK,
        K_ADDR_READ,
        K_TX_ACK,
        K_HOST_POP,
        K_SET_RESP
    } kind_t;

    typedef struct packed {
        logic [3:0]        opcode;
        logic [BYTE_W-1:0] bus_byte;
        logic [WORD_W-1:0] response_word;
    } in_t;

    typedef struct packed {
        logic                   ack;
        logic                   tx_valid;
        logic [BYTE_W-1:0]      tx_byte;
        logic                   word_valid;
        logic [WORD_W-1:0]      word_out;
        logic [OUT_COUNT_W-1:0] words_waiting;
        logic                   overflow;
    } out_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] bus_byte;
        logic [WORD_W-1:0] response_word;
    } cmd_entry_t;

    // Front to back: head of the command queue
    typedef struct packed {
        logic       valid;
        cmd_entry_t entry;
    } queue_head_t;

    // Back to word ring
    typedef struct packed {
        logic              push;
        logic [WORD_W-1:0] push_data;
        logic              pop;
    } ring_ctl_t;

endpackage

[src/iswm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iswm_front: command intake
// Accepts items, decodes the opcode into a command kind and holds them in a
// two-entry queue for the execution unit.
// ----------------------------------------------------------------------------
module iswm_front
    import iswm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_t         cmd,
    output queue_head_t head,
    input  logic        head_pop
);

    cmd_entry_t q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;
    kind_t      kind;

    always_comb
    begin
        case (cmd.opcode)
            OPC_ADDR_WRITE: kind = K_ADDR_WRITE;
            OPC_BYTE_RX:    kind = K_BYTE_RX;
            OPC_STOP:       kind = K_STOP;
            OPC_RX_NACK:    kind = K_RX_NACK;
            OPC_ADDR_READ:  kind = K_ADDR_READ;
            OPC_TX_ACK:     kind = K_TX_ACK;
            OPC_HOST_POP:   kind = K_HOST_POP;
            OPC_SET_RESP:   kind = K_SET_RESP;
            default:        kind = K_NONE;
        endcase
    end

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign pop  = head_pop && (cnt_reg != 2'd0);

    assign head.valid = (cnt_reg != 2'd0);
    assign head.entry = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{kind: kind, bus_byte: cmd.bus_byte,
                                   response_word: cmd.response_word};
        end
    end

endmodule

[src/iswm_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iswm_ring: word ring
// Circular store of received words with a saturating fill count. A push
// into a full ring is dropped; a pop registers the oldest word.
// ----------------------------------------------------------------------------
module iswm_ring
    import iswm_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF,
    localparam int PW = $clog2(BUF_DEPTH),
    localparam int CW = $clog2(BUF_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ring_ctl_t         ctl,
    output logic [CW-1:0]     count,
    output logic              full,
    output logic [WORD_W-1:0] rd_data
);

    localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);
    localparam logic [PW-1:0] LAST_C  = PW'(BUF_DEPTH - 1);

    logic [WORD_W-1:0] ring_mem [BUF_DEPTH];
    logic [WORD_W-1:0] rd_reg;
    logic [PW-1:0]     put_ptr_reg, put_ptr_next;
    logic [PW-1:0]     get_ptr_reg, get_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push_ok;
    logic              pop_ok;

    assign full    = (count_reg == DEPTH_C);
    assign push_ok = ctl.push && !full;
    assign pop_ok  = ctl.pop && (count_reg != '0);
    assign count   = count_reg;
    assign rd_data = rd_reg;

    always_comb
    begin
        put_ptr_next = put_ptr_reg;
        get_ptr_next = get_ptr_reg;
        if (push_ok)
        begin
            put_ptr_next = (put_ptr_reg == LAST_C) ? '0 : put_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            get_ptr_next = (get_ptr_reg == LAST_C) ? '0 : get_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push_ok) - CW'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            put_ptr_reg <= '0;
            get_ptr_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            put_ptr_reg <= put_ptr_next;
            get_ptr_reg <= get_ptr_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            ring_mem[put_ptr_reg] <= ctl.push_data;
        end
        if (pop_ok)
        begin
            rd_reg <= ring_mem[get_ptr_reg];
        end
    end

endmodule

[src/iswm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iswm_back: command execution
// Carries out one queued command at a time: byte intake with word packing,
// the stop-time copy of packed words into the ring, host pops, and the
// response transmit path. Drives the registered result strobe.
// ----------------------------------------------------------------------------
module iswm_back
    import iswm_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF,
    localparam int CW  = $clog2(BUF_DEPTH + 1),
    localparam int RCW = $clog2(BUF_DEPTH + 1),
    localparam int SD  = BUF_DEPTH / 4,
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1,
    localparam int SIW = $clog2(SD + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  queue_head_t       head,
    output logic              head_pop,
    output ring_ctl_t         ring_ctl,
    input  logic [CW-1:0]     ring_count,
    input  logic              ring_full,
    input  logic [WORD_W-1:0] ring_rd_data,
    output logic              done,
    output out_t              result
);

    localparam logic [RCW-1:0] DEPTH_C = RCW'(BUF_DEPTH);
    localparam logic [2:0]     POS_END = 3'(TX_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_COPY
    } state_t;

    state_t            state_reg, state_next;
    logic [RCW-1:0]    rx_count_reg, rx_count_next;
    logic [23:0]       asm_reg, asm_next;
    logic [WORD_W-1:0] response_reg, response_next;
    logic [WORD_W-1:0] shadow_reg, shadow_next;
    logic [2:0]        tx_pos_reg, tx_pos_next;
    logic [SIW-1:0]    nwords_reg, nwords_next;
    logic [SIW-1:0]    rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic              ovf_reg, ovf_next;
    logic              done_reg, done_next;
    logic              ack_reg, ack_next;
    logic              tx_valid_reg, tx_valid_next;
    logic [BYTE_W-1:0] tx_byte_reg, tx_byte_next;
    logic              word_valid_reg, word_valid_next;
    logic [WORD_W-1:0] word_out_reg, word_out_next;
    logic              overflow_reg, overflow_next;

    logic [WORD_W-1:0] stage_mem [SD];
    logic [WORD_W-1:0] stage_rd_reg;
    logic              stage_we;
    logic              stage_re;
    logic [RCW-1:0]    rx_word_idx;
    logic [WORD_W-1:0] tx_shift;
    logic [CW+5:0]     count_ext;
    cmd_entry_t        e;

    assign e           = head.entry;
    assign rx_word_idx = rx_count_reg >> 2;
    assign tx_shift    = shadow_reg >> {tx_pos_reg[1:0], 3'b000};
    assign count_ext   = {6'd0, ring_count};

    always_comb
    begin
        state_next      = state_reg;
        rx_count_next   = rx_count_reg;
        asm_next        = asm_reg;
        response_next   = response_reg;
        shadow_next     = shadow_reg;
        tx_pos_next     = tx_pos_reg;
        nwords_next     = nwords_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = 1'b0;
        ovf_next        = ovf_reg;
        done_next       = 1'b0;
        ack_next        = ack_reg;
        tx_valid_next   = tx_valid_reg;
        tx_byte_next    = tx_byte_reg;
        word_valid_next = word_valid_reg;
        word_out_next   = word_out_reg;
        overflow_next   = overflow_reg;
        head_pop        = 1'b0;
        stage_we        = 1'b0;
        stage_re        = 1'b0;
        ring_ctl.push      = 1'b0;
        ring_ctl.push_data = stage_rd_reg;
        ring_ctl.pop       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    head_pop        = 1'b1;
                    done_next       = 1'b1;
                    ack_next        = 1'b1;
                    tx_valid_next   = 1'b0;
                    tx_byte_next    = '0;
                    word_valid_next = 1'b0;
                    word_out_next   = '0;
                    overflow_next   = 1'b0;
                    case (e.kind)
                        K_ADDR_WRITE:
                        begin
                            rx_count_next = '0;
                        end
                        K_BYTE_RX:
                        begin
                            if (rx_count_reg < DEPTH_C)
                            begin
                                // every fourth byte completes a word
                                if (rx_count_reg[1:0] == 2'b11)
                                begin
                                    stage_we = 1'b1;
                                end
                                asm_next      = {asm_reg[15:0], e.bus_byte};
                                rx_count_next = rx_count_reg + 1'b1;
                            end
                            else
                            begin
                                ack_next = 1'b0;
                            end
                        end
                        K_STOP:
                        begin
                            rx_count_next = '0;
                            if ((rx_count_reg[1:0] == 2'b00) && (rx_count_reg != '0))
                            begin
                                done_next   = 1'b0;
                                nwords_next = rx_word_idx[SIW-1:0];
                                rd_idx_next = '0;
                                ovf_next    = 1'b0;
                                state_next  = ST_COPY;
                            end
                        end
                        K_RX_NACK:
                        begin
                            ack_next = 1'b0;
                        end
                        K_ADDR_READ:
                        begin
                            shadow_next   = response_reg;
                            response_next = '0;
                            tx_valid_next = 1'b1;
                            tx_byte_next  = response_reg[BYTE_W-1:0];
                            tx_pos_next   = 3'd1;
                        end
                        K_TX_ACK:
                        begin
                            tx_valid_next = 1'b1;
                            if (tx_pos_reg < POS_END)
                            begin
                                tx_byte_next = tx_shift[BYTE_W-1:0];
                                tx_pos_next  = tx_pos_reg + 3'd1;
                                ack_next     = (tx_pos_reg + 3'd1) < POS_END;
                            end
                            else
                            begin
                                ack_next = 1'b0;
                            end
                        end
                        K_HOST_POP:
                        begin
                            if (ring_count != '0)
                            begin
                                ring_ctl.pop = 1'b1;
                                done_next    = 1'b0;
                                state_next   = ST_POP;
                            end
                        end
                        K_SET_RESP:
                        begin
                            response_next = e.response_word;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                done_next       = 1'b1;
                word_valid_next = 1'b1;
                word_out_next   = ring_rd_data;
                state_next      = ST_IDLE;
            end
            ST_COPY:
            begin
                // read one packed word per cycle, push it the cycle after
                stage_re    = (rd_idx_reg < nwords_reg);
                pend_next   = stage_re;
                rd_idx_next = stage_re ? rd_idx_reg + 1'b1 : rd_idx_reg;
                if (pend_reg)
                begin
                    ring_ctl.push = 1'b1;
                    if (ring_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (!stage_re)
                    begin
                        done_next     = 1'b1;
                        overflow_next = ovf_reg || ring_full;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rx_count_reg   <= '0;
            response_reg   <= '0;
            shadow_reg     <= '0;
            tx_pos_reg     <= '0;
            nwords_reg     <= '0;
            rd_idx_reg     <= '0;
            pend_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rx_count_reg   <= rx_count_next;
            response_reg   <= response_next;
            shadow_reg     <= shadow_next;
            tx_pos_reg     <= tx_pos_next;
            nwords_reg     <= nwords_next;
            rd_idx_reg     <= rd_idx_next;
            pend_reg       <= pend_next;
            ovf_reg        <= ovf_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        asm_reg        <= asm_next;
        ack_reg        <= ack_next;
        tx_valid_reg   <= tx_valid_next;
        tx_byte_reg    <= tx_byte_next;
        word_valid_reg <= word_valid_next;
        word_out_reg   <= word_out_next;
        overflow_reg   <= overflow_next;
    end

    always_ff @(posedge clk)
    begin
        if (stage_we)
        begin
            stage_mem[rx_word_idx[SAW-1:0]] <= {asm_reg, e.bus_byte};
        end
        if (stage_re)
        begin
            stage_rd_reg <= stage_mem[rd_idx_reg[SAW-1:0]];
        end
    end

    assign done                 = done_reg;
    assign result.ack           = ack_reg;
    assign result.tx_valid      = tx_valid_reg;
    assign result.tx_byte       = tx_byte_reg;
    assign result.word_valid    = word_valid_reg;
    assign result.word_out      = word_out_reg;
    assign result.words_waiting = count_ext[OUT_COUNT_W-1:0];
    assign result.overflow      = overflow_reg;

endmodule

[src/i2c_slave_word_mailbox.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_word_mailbox: I2C slave word mailbox
// Decoded I2C slave events and host accesses in; one result per item out.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; a two-entry command
// queue sits in front of the execution unit, so busy rises only when both
// entries are held. Every item yields exactly one result, shown on result for
// a single cycle with done high; it cannot be held off, so sample it then.
// Results come in item order. A host pop with words waiting passes through a
// pop state while the ring registers the oldest word, and a stop that packs
// words copies them one word per cycle from the packed-word store into the
// word ring, with done following the last push. A word pushed into a full ring
// is dropped and flags overflow; bytes read past the fourth come out as zero.
// ----------------------------------------------------------------------------
module i2c_slave_word_mailbox
    import iswm_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  cmd,
    output logic done,
    output out_t result
);

    localparam int CW = $clog2(BUF_DEPTH + 1);

    queue_head_t       head;
    logic              head_pop;
    ring_ctl_t         ring_ctl;
    logic [CW-1:0]     ring_count;
    logic              ring_full;
    logic [WORD_W-1:0] ring_rd_data;

    iswm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .head     (head),
        .head_pop (head_pop)
    );

    iswm_ring #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ring_ctl),
        .count   (ring_count),
        .full    (ring_full),
        .rd_data (ring_rd_data)
    );

    iswm_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_pop     (head_pop),
        .ring_ctl     (ring_ctl),
        .ring_count   (ring_count),
        .ring_full    (ring_full),
        .ring_rd_data (ring_rd_data),
        .done         (done),
        .result       (result)
    );

endmodule
